// ===== src/dstg_pkg.sv =====
// Shared types and constants for the decaying sine tone generator.
package dstg_pkg;

   // Default sizes of the generator.
   localparam int SINE_TABLE_ENTRIES_DEFAULT = 256;
   localparam int INDEX_BITS_DEFAULT = 20;
   localparam int PHASE_BITS_DEFAULT = 32;

   // Fixed widths of the register file and of the result word.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam int NOTE_LENGTH_BITS = 20;
   localparam int VOLUME_BITS = 16;
   localparam int SAMPLE_BITS = 16;
   localparam int MAG_BITS = 16;
   localparam int ENV_BITS = 17;
   localparam int MUL_BITS = 32;
   localparam int PROD_BITS = 64;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NOTE_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LENGTH_RECIPROCAL = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VOLUME = 2'd3;

   // Fixed-point constants of the sine table and of the output scale.
   localparam logic [63:0] Q30_ONE = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [MUL_BITS-1:0] FULL_SCALE = 32'd32760;

   // Program counter of the sequencer.
   localparam int PC_BITS = 3;

   // Operand pairs of the shared multiplier.
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_FADE,
      MUL_SINE,
      MUL_GAIN,
      MUL_SCALE
   } mul_op_type;

   // Controls that the sequencer drives into the datapath.
   typedef struct packed {
      mul_op_type mul_op;
      logic       check;
      logic       load_env;
      logic       take_req;
      logic       put_rsp;
   } ctrl_type;

   // Status that the datapath returns to the sequencer.
   typedef struct packed {
      logic note_live;
      logic out_free;
   } status_type;

endpackage

// ===== src/dstg_sine_rom.sv =====
// Quarter-wave sine table built at elaboration, with a registered read port.
module dstg_sine_rom #(
   parameter int SINE_TABLE_ENTRIES = dstg_pkg::SINE_TABLE_ENTRIES_DEFAULT
) (
   input  logic                                         clock,
   input  logic [$clog2(SINE_TABLE_ENTRIES+1)-1:0]      rd_addr,
   output logic [dstg_pkg::MAG_BITS-1:0]                rd_data
);

   localparam int KW = $clog2(SINE_TABLE_ENTRIES + 1);

   // sin(pi/2 * k / entries) in unsigned Q1.15 from a truncated Taylor series.
   function automatic logic [dstg_pkg::MAG_BITS-1:0] sine_value(input logic [KW-1:0] k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      x  = (64'(k) * dstg_pkg::HALF_PI_Q30) / 64'(SINE_TABLE_ENTRIES);
      x2 = (x * x) >> 30;
      t  = dstg_pkg::Q30_ONE - x2 / 64'd110;
      t  = dstg_pkg::Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = dstg_pkg::Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = dstg_pkg::Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = dstg_pkg::Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      t  = (x * t) >> 30;
      return dstg_pkg::MAG_BITS'((t + 64'd16384) >> 15);
   endfunction

   logic [dstg_pkg::MAG_BITS-1:0] table_w [0:SINE_TABLE_ENTRIES];
   logic [dstg_pkg::MAG_BITS-1:0] rd_data_ff;
   logic [dstg_pkg::MAG_BITS-1:0] rd_data_in;

   // Constant entries, one per table point including the peak.
   for (genvar g = 0; g <= SINE_TABLE_ENTRIES; g++) begin : g_entry
      assign table_w[g] = sine_value(KW'(g));
   end

   // Registered read.
   assign rd_data_in = table_w[rd_addr];

   always_ff @(posedge clock) begin
      rd_data_ff <= rd_data_in;
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/dstg_sequencer.sv =====
// Microcode sequencer: step counter, program table and branch logic.
module dstg_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dstg_pkg::status_type status,
   output dstg_pkg::ctrl_type   ctrl
);

   typedef enum logic [1:0] {
      BR_NEXT,
      BR_WAIT_REQ,
      BR_IF_IDLE,
      BR_WAIT_OUT
   } branch_type;

   typedef struct packed {
      branch_type                   branch;
      logic [dstg_pkg::PC_BITS-1:0] target;
      dstg_pkg::mul_op_type         mul_op;
      logic                         check;
      logic                         load_env;
      logic                         emit;
   } uword_type;

   // Step addresses of the program.
   localparam logic [dstg_pkg::PC_BITS-1:0] STEP_WAIT  = 3'd0;
   localparam logic [dstg_pkg::PC_BITS-1:0] STEP_FADE  = 3'd1;
   localparam logic [dstg_pkg::PC_BITS-1:0] STEP_ENV   = 3'd2;
   localparam logic [dstg_pkg::PC_BITS-1:0] STEP_SINE  = 3'd3;
   localparam logic [dstg_pkg::PC_BITS-1:0] STEP_GAIN  = 3'd4;
   localparam logic [dstg_pkg::PC_BITS-1:0] STEP_SCALE = 3'd5;
   localparam logic [dstg_pkg::PC_BITS-1:0] STEP_EMIT  = 3'd6;

   // The program: one control word per step.
   function automatic uword_type program_word(input logic [dstg_pkg::PC_BITS-1:0] pc);
      uword_type w;
      w = '{branch: BR_NEXT, target: STEP_WAIT, mul_op: dstg_pkg::MUL_NONE,
            check: 1'b0, load_env: 1'b0, emit: 1'b0};
      case (pc)
         STEP_WAIT: begin
            w.branch = BR_WAIT_REQ;
         end
         STEP_FADE: begin
            w.branch = BR_IF_IDLE;
            w.target = STEP_EMIT;
            w.mul_op = dstg_pkg::MUL_FADE;
            w.check  = 1'b1;
         end
         STEP_ENV: begin
            w.load_env = 1'b1;
         end
         STEP_SINE: begin
            w.mul_op = dstg_pkg::MUL_SINE;
         end
         STEP_GAIN: begin
            w.mul_op = dstg_pkg::MUL_GAIN;
         end
         STEP_SCALE: begin
            w.mul_op = dstg_pkg::MUL_SCALE;
         end
         STEP_EMIT: begin
            w.branch = BR_WAIT_OUT;
            w.target = STEP_WAIT;
            w.emit   = 1'b1;
         end
         default: begin
            w.branch = BR_NEXT;
            w.target = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

   logic [dstg_pkg::PC_BITS-1:0] pc_ff;
   logic [dstg_pkg::PC_BITS-1:0] pc_in;
   logic [dstg_pkg::PC_BITS-1:0] pc_next;
   uword_type                    word;

   assign word = program_word(pc_ff);
   assign pc_next = pc_ff + 3'd1;

   // Branch resolution.
   always_comb begin
      case (word.branch)
         BR_NEXT:     pc_in = pc_next;
         BR_WAIT_REQ: pc_in = req_valid ? pc_next : pc_ff;
         BR_IF_IDLE:  pc_in = status.note_live ? pc_next : word.target;
         BR_WAIT_OUT: pc_in = status.out_free ? word.target : pc_ff;
         default:     pc_in = STEP_WAIT;
      endcase
      if (pc_ff == STEP_EMIT + 3'd1) begin
         pc_in = STEP_WAIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // Controls for the datapath.
   assign req_ready     = (word.branch == BR_WAIT_REQ);
   assign ctrl.mul_op   = word.mul_op;
   assign ctrl.check    = word.check;
   assign ctrl.load_env = word.load_env;
   assign ctrl.take_req = req_ready & req_valid;
   assign ctrl.put_rsp  = word.emit & status.out_free;

endmodule

// ===== src/dstg_datapath.sv =====
// Datapath: registers, note state, shared multiplier and output register.
module dstg_datapath #(
   parameter int SINE_TABLE_ENTRIES = dstg_pkg::SINE_TABLE_ENTRIES_DEFAULT,
   parameter int INDEX_BITS = dstg_pkg::INDEX_BITS_DEFAULT,
   parameter int PHASE_BITS = dstg_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  dstg_pkg::ctrl_type                      ctrl,
   output dstg_pkg::status_type                    status,
   input  logic                                    req_start_req,
   input  logic                                    csr_valid,
   input  logic [dstg_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [dstg_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   output logic [$clog2(SINE_TABLE_ENTRIES+1)-1:0] rom_addr,
   input  logic [dstg_pkg::MAG_BITS-1:0]           rom_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [dstg_pkg::SAMPLE_BITS-1:0] rsp_sample,
   output logic                                    rsp_active,
   output logic                                    rsp_last
);

   localparam int KW = $clog2(SINE_TABLE_ENTRIES + 1);
   localparam int FB = PHASE_BITS - 2;
   localparam int FKW = FB + KW;

   // Configuration registers.
   logic [31:0]                         phase_step_ff, phase_step_in;
   logic [dstg_pkg::NOTE_LENGTH_BITS-1:0] note_length_ff, note_length_in;
   logic [31:0]                         length_reciprocal_ff, length_reciprocal_in;
   logic [dstg_pkg::VOLUME_BITS-1:0]    volume_ff, volume_in;

   // Note state.
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [INDEX_BITS-1:0] index_ff, index_in;
   logic                  playing_ff, playing_in;

   // Working registers.
   logic [dstg_pkg::PROD_BITS-1:0] prod_ff, prod_in;
   logic [dstg_pkg::ENV_BITS-1:0]  env_ff, env_in;
   logic [KW-1:0]                  k_ff, k_in;
   logic                           neg_ff, neg_in;

   // Output register.
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic signed [dstg_pkg::SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                                    rsp_active_ff, rsp_active_in;
   logic                                    rsp_last_ff, rsp_last_in;

   logic [INDEX_BITS-1:0]          len;
   logic                           note_live;
   logic                           is_last;
   logic [FKW-1:0]                 fk;
   logic [KW-1:0]                  k_raw;
   logic [32:0]                    env_full;
   logic [dstg_pkg::MUL_BITS-1:0]  mul_a;
   logic [dstg_pkg::MUL_BITS-1:0]  mul_b;
   logic [16:0]                    mag_m;
   logic [16:0]                    mag_clamped;
   logic [dstg_pkg::SAMPLE_BITS-1:0] sample_value;

   // Register writes.
   always_comb begin
      phase_step_in        = phase_step_ff;
      note_length_in       = note_length_ff;
      length_reciprocal_in = length_reciprocal_ff;
      volume_in            = volume_ff;
      if (csr_valid) begin
         case (csr_index)
            dstg_pkg::CSR_PHASE_STEP:        phase_step_in = csr_wdata;
            dstg_pkg::CSR_NOTE_LENGTH:
               note_length_in = csr_wdata[dstg_pkg::NOTE_LENGTH_BITS-1:0];
            dstg_pkg::CSR_LENGTH_RECIPROCAL: length_reciprocal_in = csr_wdata;
            dstg_pkg::CSR_VOLUME:
               volume_in = csr_wdata[dstg_pkg::VOLUME_BITS-1:0];
            default: begin
               phase_step_in = phase_step_ff;
            end
         endcase
      end
   end

   // Note length as seen by the index counter.
   assign len       = INDEX_BITS'(note_length_ff);
   assign note_live = playing_ff && (index_ff < len);
   assign is_last   = ((INDEX_BITS+1)'(index_ff) + (INDEX_BITS+1)'(1))
                      == (INDEX_BITS+1)'(len);

   // Table address from the phase: quadrant mirror of the fraction.
   assign fk    = FKW'(phase_ff[FB-1:0]) * FKW'(SINE_TABLE_ENTRIES);
   assign k_raw = fk[FKW-1:FB];
   assign k_in  = phase_ff[FB] ? (KW'(SINE_TABLE_ENTRIES) - k_raw) : k_raw;
   assign neg_in = phase_ff[PHASE_BITS-1];
   assign rom_addr = k_ff;

   // Fade envelope: 2^32 minus the index times the slope, floored at zero.
   assign env_full = 33'h1_0000_0000 - {1'b0, prod_ff[31:0]};
   assign env_in   = (prod_ff[63:32] != 32'd0) ? '0 : env_full[32:16];

   // Operand selection for the shared multiplier.
   always_comb begin
      case (ctrl.mul_op)
         dstg_pkg::MUL_FADE: begin
            mul_a = 32'(index_ff);
            mul_b = length_reciprocal_ff;
         end
         dstg_pkg::MUL_SINE: begin
            mul_a = 32'(rom_data);
            mul_b = 32'(env_ff);
         end
         dstg_pkg::MUL_GAIN: begin
            mul_a = prod_ff[47:16];
            mul_b = 32'(volume_ff);
         end
         dstg_pkg::MUL_SCALE: begin
            mul_a = prod_ff[31:0];
            mul_b = dstg_pkg::FULL_SCALE;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = (ctrl.mul_op == dstg_pkg::MUL_NONE) ? prod_ff
                  : ({32'd0, mul_a} * {32'd0, mul_b});

   // Final shift, saturation and sign of the sample.
   assign mag_m = prod_ff[46:30];
   always_comb begin
      if (neg_ff) begin
         mag_clamped  = (mag_m > 17'd32768) ? 17'd32768 : mag_m;
         sample_value = dstg_pkg::SAMPLE_BITS'(17'h10000 - mag_clamped);
      end else begin
         mag_clamped  = (mag_m > 17'd32767) ? 17'd32767 : mag_m;
         sample_value = dstg_pkg::SAMPLE_BITS'(mag_clamped);
      end
   end

   // Note state updates: start on a request, end check, advance on emit.
   always_comb begin
      phase_in   = phase_ff;
      index_in   = index_ff;
      playing_in = playing_ff;
      if (ctrl.take_req && req_start_req) begin
         phase_in   = '0;
         index_in   = '0;
         playing_in = (len != '0);
      end
      if (ctrl.check) begin
         playing_in = note_live;
      end
      if (ctrl.put_rsp && playing_ff) begin
         phase_in = phase_ff + PHASE_BITS'(phase_step_ff);
         index_in = index_ff + INDEX_BITS'(1);
         if (is_last) begin
            playing_in = 1'b0;
         end
      end
   end

   // Output register: loaded on emit, emptied when the word is taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_active_in = rsp_active_ff;
      rsp_last_in   = rsp_last_ff;
      if (ctrl.put_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = playing_ff ? sample_value : '0;
         rsp_active_in = playing_ff;
         rsp_last_in   = playing_ff & is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff        <= '0;
         note_length_ff       <= '0;
         length_reciprocal_ff <= '0;
         volume_ff            <= '0;
         phase_ff             <= '0;
         index_ff             <= '0;
         playing_ff           <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         phase_step_ff        <= phase_step_in;
         note_length_ff       <= note_length_in;
         length_reciprocal_ff <= length_reciprocal_in;
         volume_ff            <= volume_in;
         phase_ff             <= phase_in;
         index_ff             <= index_in;
         playing_ff           <= playing_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
   end

   // Payload registers without reset.
   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_active_ff <= rsp_active_in;
      rsp_last_ff   <= rsp_last_in;
      if (ctrl.load_env) begin
         env_ff <= env_in;
      end
      if (ctrl.check) begin
         k_ff   <= k_in;
         neg_ff <= neg_in;
      end
   end

   assign status.note_live = note_live;
   assign status.out_free  = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_active = rsp_active_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ===== src/decaying_sine_tone_generator.sv =====
// Decaying sine tone generator: one audio sample word per request word.
// The word is registered in EMIT, after FADE, ENV, SINE, GAIN and SCALE (after
// FADE only for an idle or finished note); EMIT waits while the output is full.
// No request is taken before then; the microcode program runs the fade, sine,
// gain and scale products through one shared 32x32 multiplier.
// Reset clears the configuration registers, the phase, the sample index, the playing flag and the output valid flag.
module decaying_sine_tone_generator #(
   parameter int SINE_TABLE_ENTRIES = dstg_pkg::SINE_TABLE_ENTRIES_DEFAULT,
   parameter int INDEX_BITS = dstg_pkg::INDEX_BITS_DEFAULT,
   parameter int PHASE_BITS = dstg_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_start_req,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [dstg_pkg::SAMPLE_BITS-1:0] rsp_sample,
   output logic                                    rsp_active,
   output logic                                    rsp_last,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [dstg_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [dstg_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int KW = $clog2(SINE_TABLE_ENTRIES + 1);

   dstg_pkg::ctrl_type            ctrl;
   dstg_pkg::status_type          status;
   logic [KW-1:0]                 rom_addr;
   logic [dstg_pkg::MAG_BITS-1:0] rom_data;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   // Program sequencer.
   dstg_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   // Sine table.
   dstg_sine_rom #(
      .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
   ) u_sine_rom (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   // Arithmetic and state.
   dstg_datapath #(
      .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
      .INDEX_BITS         (INDEX_BITS),
      .PHASE_BITS         (PHASE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .status        (status),
      .req_start_req (req_start_req),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rom_addr      (rom_addr),
      .rom_data      (rom_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_sample    (rsp_sample),
      .rsp_active    (rsp_active),
      .rsp_last      (rsp_last)
   );

endmodule
